/* src/pst_pkg.sv */
// Shared types and constants for the point store with radius search.
// Used by every module of the block; depends on nothing.
package pst_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned R2_W           = 2 * COORD_W;
  localparam int unsigned DIST_W         = R2_W + 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

/* src/point_store_radius_search.sv */
// Point store with fixed-radius nearest search, remove and compaction.
// Clear and append answer one cycle after the request is accepted.
// Query and remove walk the store at one memory read per cycle; one
// request is in work at a time.
// Reset clears the point count and control state; stored points are kept.
// Depends on pst_pkg, pst_mem and pst_dist.
module point_store_radius_search #(
  parameter int unsigned MAX_POINTS = pst_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic [15:0]        in_radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_nearest_found,
  output logic [7:0]         out_nearest_index,
  output logic [8:0]         out_within_count,
  output logic [8:0]         out_removed_count,
  output logic [8:0]         out_stored_count,
  output logic               out_append_rejected
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW = pst_pkg::DIST_W;
  localparam int unsigned RW = pst_pkg::R2_W;

  pst_pkg::state_t state_r, state_nxt;
  pst_pkg::op_t    op_r, op_nxt;
  pst_pkg::point_t probe_r, probe_nxt;
  logic [RW-1:0]   r2_r, r2_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   rd_i_r, rd_i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   within_r, within_nxt;
  logic [DW-1:0]   best_r, best_nxt;
  logic [AW-1:0]   nidx_r, nidx_nxt;
  logic            found_r, found_nxt;
  logic            rv_r;
  logic [AW-1:0]   ridx_r;

  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r, out_found_nxt;
  logic [7:0]      out_index_r, out_index_nxt;
  logic [8:0]      out_within_r, out_within_nxt;
  logic [8:0]      out_removed_r, out_removed_nxt;
  logic [8:0]      out_stored_r, out_stored_nxt;
  logic            out_rej_r, out_rej_nxt;

  logic            accept;
  logic [RW-1:0]   r2_in;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  pst_pkg::point_t wr_data;
  pst_pkg::point_t rd_data;
  pst_pkg::point_t in_pt;

  logic            e_vld;
  logic [AW-1:0]   e_idx;
  pst_pkg::point_t e_pt;
  logic [DW-1:0]   e_dist;
  logic            dist_busy;
  logic            hit;

  logic [CW+8:0]   stored_wide, within_wide, removed_wide;
  logic [AW+7:0]   nidx_wide;
  logic [CW-1:0]   removed_val;

  assign in_pt   = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
  assign in_ready = (state_r == pst_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept  = in_valid && in_ready;
  assign r2_in   = RW'(in_radius) * RW'(in_radius);
  assign rd_en   = (state_r == pst_pkg::ST_SCAN) && (rd_i_r < cnt_r);
  assign hit     = e_dist < DW'(r2_r);

  assign removed_val  = cnt_r - j_r;
  assign within_wide  = {9'b0, within_r};
  assign removed_wide = {9'b0, removed_val};
  assign stored_wide  = {9'b0, j_r};
  assign nidx_wide    = {8'b0, nidx_r};

  pst_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_i_r[AW-1:0]),
    .rd_data (rd_data)
  );

  pst_dist #(
    .AW (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rv_r),
    .in_idx   (ridx_r),
    .in_pt    (rd_data),
    .probe    (probe_r),
    .res_vld  (e_vld),
    .res_idx  (e_idx),
    .res_pt   (e_pt),
    .res_dist (e_dist),
    .busy     (dist_busy)
  );

  always_comb begin
    logic [CW+8:0] cnt_wide;
    state_nxt       = state_r;
    op_nxt          = op_r;
    probe_nxt       = probe_r;
    r2_nxt          = r2_r;
    cnt_nxt         = cnt_r;
    rd_i_nxt        = rd_i_r;
    j_nxt           = j_r;
    within_nxt      = within_r;
    best_nxt        = best_r;
    nidx_nxt        = nidx_r;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_found_nxt   = out_found_r;
    out_index_nxt   = out_index_r;
    out_within_nxt  = out_within_r;
    out_removed_nxt = out_removed_r;
    out_stored_nxt  = out_stored_r;
    out_rej_nxt     = out_rej_r;
    wr_en           = 1'b0;
    wr_addr         = cnt_r[AW-1:0];
    wr_data         = in_pt;
    cnt_wide        = '0;

    case (state_r)
      pst_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt          = pst_pkg::op_t'(in_opcode);
          probe_nxt       = in_pt;
          r2_nxt          = r2_in;
          out_found_nxt   = 1'b0;
          out_index_nxt   = '0;
          out_within_nxt  = '0;
          out_removed_nxt = '0;
          out_rej_nxt     = 1'b0;
          case (pst_pkg::op_t'(in_opcode))
            pst_pkg::OP_CLEAR: begin
              cnt_nxt        = '0;
              out_stored_nxt = '0;
              out_valid_nxt  = 1'b1;
            end
            pst_pkg::OP_APPEND: begin
              if (cnt_r >= CW'(MAX_POINTS)) begin
                out_rej_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              cnt_wide       = {9'b0, cnt_nxt};
              out_stored_nxt = cnt_wide[8:0];
              out_valid_nxt  = 1'b1;
            end
            default: begin
              state_nxt  = pst_pkg::ST_SCAN;
              rd_i_nxt   = '0;
              j_nxt      = '0;
              within_nxt = '0;
              best_nxt   = DW'(r2_in);
              nidx_nxt   = '0;
              found_nxt  = 1'b0;
            end
          endcase
        end
      end
      pst_pkg::ST_SCAN: begin
        if (rd_en) begin
          rd_i_nxt = rd_i_r + 1'b1;
        end
        if (e_vld) begin
          if (op_r == pst_pkg::OP_QUERY) begin
            if (hit) begin
              within_nxt = within_r + 1'b1;
            end
            if (e_dist < best_r) begin
              best_nxt  = e_dist;
              nidx_nxt  = e_idx;
              found_nxt = 1'b1;
            end
          end else if (!hit) begin
            // Survivors move down to the compaction pointer, which never
            // passes the entry being read.
            wr_en   = 1'b1;
            wr_addr = j_r[AW-1:0];
            wr_data = e_pt;
            j_nxt   = j_r + 1'b1;
          end
        end
        if (!rd_en && !rv_r && !dist_busy) begin
          state_nxt = pst_pkg::ST_DONE;
        end
      end
      pst_pkg::ST_DONE: begin
        state_nxt     = pst_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        if (op_r == pst_pkg::OP_QUERY) begin
          out_found_nxt  = found_r;
          out_index_nxt  = nidx_wide[7:0];
          out_within_nxt = within_wide[8:0];
          cnt_wide       = {9'b0, cnt_r};
          out_stored_nxt = cnt_wide[8:0];
        end else begin
          out_removed_nxt = removed_wide[8:0];
          out_stored_nxt  = stored_wide[8:0];
          cnt_nxt         = j_r;
        end
      end
      default: begin
        state_nxt = pst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pst_pkg::ST_IDLE;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    probe_r       <= probe_nxt;
    r2_r          <= r2_nxt;
    rd_i_r        <= rd_i_nxt;
    j_r           <= j_nxt;
    within_r      <= within_nxt;
    best_r        <= best_nxt;
    nidx_r        <= nidx_nxt;
    found_r       <= found_nxt;
    ridx_r        <= rd_i_r[AW-1:0];
    out_found_r   <= out_found_nxt;
    out_index_r   <= out_index_nxt;
    out_within_r  <= out_within_nxt;
    out_removed_r <= out_removed_nxt;
    out_stored_r  <= out_stored_nxt;
    out_rej_r     <= out_rej_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_found   = out_found_r;
  assign out_nearest_index   = out_index_r;
  assign out_within_count    = out_within_r;
  assign out_removed_count   = out_removed_r;
  assign out_stored_count    = out_stored_r;
  assign out_append_rejected = out_rej_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pst_pkg::ST_SCAN) && wr_en |-> wr_addr < rd_i_r[AW-1:0] || !rd_en)
    else $error("compaction write reaches an entry not yet read");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register is not one-hot");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pst_pkg::ST_DONE |=> out_valid_r && state_r == pst_pkg::ST_IDLE)
    else $error("scan finished without presenting a result");

  a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pst_pkg::ST_SCAN |-> !out_valid_r)
    else $error("result pending while a scan is running");

endmodule

/* src/pst_mem.sv */
// Point storage: one write port and one read port with registered read data.
// Depends on pst_pkg for the point type.
module pst_mem #(
  parameter int unsigned DEPTH = pst_pkg::MAX_POINTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  pst_pkg::point_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output pst_pkg::point_t  rd_data
);

  pst_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/pst_dist.sv */
// Three-stage squared-distance pipeline: difference, square, sum.
// Carries the entry index and point alongside. Depends on pst_pkg.
module pst_dist #(
  parameter int unsigned AW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [AW-1:0]              in_idx,
  input  pst_pkg::point_t            in_pt,
  input  pst_pkg::point_t            probe,
  output logic                       res_vld,
  output logic [AW-1:0]              res_idx,
  output pst_pkg::point_t            res_pt,
  output logic [pst_pkg::DIST_W-1:0] res_dist,
  output logic                       busy
);

  localparam int unsigned DW = pst_pkg::COORD_W + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = pst_pkg::R2_W;

  logic                 v1_r, v2_r, v3_r;
  logic [AW-1:0]        idx1_r, idx2_r, idx3_r;
  pst_pkg::point_t      pt1_r, pt2_r, pt3_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [SW-1:0]        sqx_r, sqy_r, sqz_r;
  logic [pst_pkg::DIST_W-1:0] sum_r;

  logic signed [DW-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [PW-1:0] px, py, pz;

  assign dx_nxt = DW'(in_pt.x) - DW'(probe.x);
  assign dy_nxt = DW'(in_pt.y) - DW'(probe.y);
  assign dz_nxt = DW'(in_pt.z) - DW'(probe.z);

  assign px = PW'(dx_r) * PW'(dx_r);
  assign py = PW'(dy_r) * PW'(dy_r);
  assign pz = PW'(dz_r) * PW'(dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= in_idx;
    pt1_r  <= in_pt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    idx2_r <= idx1_r;
    pt2_r  <= pt1_r;
    sqx_r  <= px[SW-1:0];
    sqy_r  <= py[SW-1:0];
    sqz_r  <= pz[SW-1:0];
    idx3_r <= idx2_r;
    pt3_r  <= pt2_r;
    sum_r  <= pst_pkg::DIST_W'(sqx_r) + pst_pkg::DIST_W'(sqy_r)
            + pst_pkg::DIST_W'(sqz_r);
  end

  assign res_vld  = v3_r;
  assign res_idx  = idx3_r;
  assign res_pt   = pt3_r;
  assign res_dist = sum_r;
  assign busy     = v1_r | v2_r | v3_r;

endmodule

/* verif/point_store_radius_search_test.sv */
// Testbench for point_store_radius_search: sends clear, append, query and remove requests
// with random idling on both channels and checks every response against a local store model.
// Depends on pst_pkg and the point_store_radius_search RTL.
module point_store_radius_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_POINTS_DEF;
  localparam int unsigned TOTAL_REQUESTS = 1350;

  typedef struct {
    logic       found;
    logic [7:0] index;
    logic [8:0] within_cnt;
    logic [8:0] removed;
    logic [8:0] stored;
    logic       rejected;
  } search_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_CLEAR;
  logic signed [15:0] in_coord_x = '0;
  logic signed [15:0] in_coord_y = '0;
  logic signed [15:0] in_coord_z = '0;
  logic [15:0]        in_radius = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_nearest_found;
  logic [7:0]         out_nearest_index;
  logic [8:0]         out_within_count;
  logic [8:0]         out_removed_count;
  logic [8:0]         out_stored_count;
  logic               out_append_rejected;

  point_t         model_points [STORE_DEPTH];
  int unsigned    model_count = 0;
  search_result_t expected_results [$];
  int unsigned    error_count = 0;
  int unsigned    results_checked = 0;
  int unsigned    requests_sent = 0;
  int unsigned    requests_per_op [4] = '{default: 0};
  int unsigned    full_store_rejects = 0;
  bit             idle_enable = 1'b1;

  point_store_radius_search i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .in_radius           (in_radius),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nearest_found   (out_nearest_found),
    .out_nearest_index   (out_nearest_index),
    .out_within_count    (out_within_count),
    .out_removed_count   (out_removed_count),
    .out_stored_count    (out_stored_count),
    .out_append_rejected (out_append_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic point_t make_point(int x, int y, int z);
    point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    return p;
  endfunction

  function automatic point_t random_point();
    return make_point($urandom, $urandom, $urandom);
  endfunction

  function automatic logic signed [15:0] jitter(logic signed [15:0] c, int unsigned spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic point_t point_near(point_t c, int unsigned spread);
    point_t p;
    p.x = jitter(c.x, spread);
    p.y = jitter(c.y, spread);
    p.z = jitter(c.z, spread);
    return p;
  endfunction

  function automatic longint dist_sq(point_t a, point_t b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Applies one request to the store model and returns the response it must produce.
  function automatic search_result_t predict_response(op_t op, point_t probe,
                                                      logic [15:0] radius);
    search_result_t res;
    longint         r2;
    longint         best;
    longint         d;
    int unsigned    kept;
    res = '{default: '0};
    r2 = longint'(radius) * longint'(radius);
    case (op)
      OP_CLEAR: begin
        model_count = 0;
      end
      OP_APPEND: begin
        if (model_count >= STORE_DEPTH) begin
          res.rejected = 1'b1;
          full_store_rejects++;
        end else begin
          model_points[model_count] = probe;
          model_count++;
        end
      end
      OP_QUERY: begin
        best = r2;
        for (int i = 0; i < model_count; i++) begin
          d = dist_sq(model_points[i], probe);
          if (d < r2) res.within_cnt++;
          if (d < best) begin
            best = d;
            res.index = i[7:0];
            res.found = 1'b1;
          end
        end
      end
      default: begin
        kept = 0;
        for (int i = 0; i < model_count; i++) begin
          if (dist_sq(model_points[i], probe) >= r2) begin
            model_points[kept] = model_points[i];
            kept++;
          end
        end
        res.removed = 9'(model_count - kept);
        model_count = kept;
      end
    endcase
    res.stored = 9'(model_count);
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("point_store_radius_search_test: mismatch: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want)
      report_error($sformatf("response %0d: %s is %0d, expected %0d",
                             results_checked, name, got, want));
  endtask

  task automatic send_request(op_t op, point_t p, logic [15:0] radius);
    int unsigned gap;
    gap = idle_enable ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_coord_x <= p.x;
    in_coord_y <= p.y;
    in_coord_z <= p.z;
    in_radius  <= radius;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_response(op, p, radius));
    requests_per_op[op]++;
    requests_sent++;
  endtask

  task automatic check_response();
    search_result_t want;
    if (expected_results.size() == 0) begin
      report_error("response arrived with no request outstanding");
      return;
    end
    want = expected_results.pop_front();
    compare_field("nearest_found", out_nearest_found, want.found);
    compare_field("nearest_index", out_nearest_index, want.index);
    compare_field("within_count", out_within_count, want.within_cnt);
    compare_field("removed_count", out_removed_count, want.removed);
    compare_field("stored_count", out_stored_count, want.stored);
    compare_field("append_rejected", out_append_rejected, want.rejected);
    results_checked++;
  endtask

  initial begin : response_checker
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_enable ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_response();
    end
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Extreme coordinates, ties, zero and full radius, and compaction after a remove.
  task automatic test_directed_cases();
    point_t lo;
    point_t hi;
    point_t origin;
    point_t twin;
    lo     = make_point(-32768, -32768, -32768);
    hi     = make_point(32767, 32767, 32767);
    origin = make_point(0, 0, 0);
    twin   = make_point(100, -100, 5);
    idle_enable = 1'b1;
    send_request(OP_CLEAR, origin, 16'd0);
    send_request(OP_QUERY, origin, 16'hFFFF);
    send_request(OP_REMOVE, origin, 16'hFFFF);
    send_request(OP_APPEND, lo, 16'd0);
    send_request(OP_APPEND, hi, 16'hFFFF);
    send_request(OP_APPEND, origin, 16'd0);
    send_request(OP_APPEND, twin, 16'd7);
    send_request(OP_APPEND, twin, 16'd9);
    send_request(OP_QUERY, twin, 16'd1);
    send_request(OP_QUERY, twin, 16'd0);
    send_request(OP_QUERY, lo, 16'hFFFF);
    send_request(OP_QUERY, hi, 16'hFFFF);
    send_request(OP_REMOVE, twin, 16'd0);
    send_request(OP_REMOVE, twin, 16'd1);
    send_request(OP_QUERY, origin, 16'hFFFF);
    send_request(OP_REMOVE, lo, 16'd40000);
    send_request(OP_QUERY, origin, 16'hFFFF);
    send_request(OP_CLEAR, hi, 16'hFFFF);
    send_request(OP_APPEND, make_point(1, 2, 3), 16'h5A5A);
    send_request(OP_QUERY, make_point(1, 2, 3), 16'd1);
    send_request(OP_CLEAR, origin, 16'd0);
  endtask

  // Fills the store to capacity, checks that further appends are dropped, then empties it.
  task automatic test_full_store();
    point_t center;
    center = random_point();
    idle_enable = ($urandom_range(0, 1) == 1);
    send_request(OP_CLEAR, random_point(), 16'($urandom));
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i == STORE_DEPTH / 2) idle_enable = !idle_enable;
      send_request(OP_APPEND, point_near(center, 2000), 16'($urandom));
    end
    idle_enable = 1'b1;
    send_request(OP_APPEND, random_point(), 16'($urandom));
    send_request(OP_APPEND, random_point(), 16'($urandom));
    send_request(OP_QUERY, random_point(), 16'($urandom));
    send_request(OP_QUERY, center, 16'hFFFF);
    send_request(OP_REMOVE, center, 16'd0);
    send_request(OP_APPEND, random_point(), 16'd0);
    send_request(OP_REMOVE, center, 16'hFFFF);
    send_request(OP_QUERY, center, 16'hFFFF);
  endtask

  // Clusters of points with queries and removes aimed at them, plus some random noise.
  task automatic test_random_traffic(int unsigned target);
    point_t      center;
    point_t      p;
    point_t      last;
    int unsigned spread;
    int unsigned n;
    logic [15:0] radius;
    op_t         op;
    last = random_point();
    while (requests_sent < target) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      center = random_point();
      case ($urandom_range(0, 2))
        0:       spread = 3;
        1:       spread = 300;
        default: spread = 5000;
      endcase
      if (model_count > 160 || $urandom_range(0, 15) == 0)
        send_request(OP_CLEAR, random_point(), 16'($urandom));
      n = $urandom_range(1, 24);
      for (int k = 0; k < n; k++) begin
        p = ($urandom_range(0, 7) == 0) ? last : point_near(center, spread);
        send_request(OP_APPEND, p, 16'($urandom));
        last = p;
      end
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          op = op_t'($urandom_range(0, 3));
          send_request(op, random_point(), 16'($urandom));
        end else begin
          case ($urandom_range(0, 7))
            0:       radius = 16'd0;
            1:       radius = 16'hFFFF;
            2:       radius = 16'($urandom);
            default: radius = 16'($urandom_range(0, 3 * spread));
          endcase
          op = ($urandom_range(0, 2) == 0) ? OP_REMOVE : OP_QUERY;
          send_request(op, point_near(center, spread), radius);
        end
      end
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (expected_results.size() > 0)
      report_error($sformatf("%0d responses never arrived", expected_results.size()));
    $display("Covered %0d clear, %0d append, %0d query and %0d remove requests,",
             requests_per_op[OP_CLEAR], requests_per_op[OP_APPEND],
             requests_per_op[OP_QUERY], requests_per_op[OP_REMOVE]);
    $display("%0d appends to a full store; %0d responses checked, %0d mismatches.",
             full_store_rejects, results_checked, error_count);
    if (error_count == 0) begin
      $display("point_store_radius_search_test: done, clean");
    end else begin
      $display("point_store_radius_search_test: done, errors");
    end
    $finish;
  endtask

  initial begin
    apply_reset();
    test_directed_cases();
    test_full_store();
    test_random_traffic(TOTAL_REQUESTS);
    finish_run();
  end

  initial begin
    #30_000_000;
    $display("point_store_radius_search_test: done, errors");
    $finish;
  end

endmodule
